FILE: sv/triangle_tile_coverage_rasterizer_core_macros.svh
// Assertion helpers for the triangle tile coverage rasterizer core.
`ifndef TRIANGLE_TILE_COVERAGE_RASTERIZER_CORE_MACROS_SVH
`define TRIANGLE_TILE_COVERAGE_RASTERIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TTCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTCR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTCR_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/ttcr_pkg.sv
package ttcr_pkg;

  localparam int unsigned TILE_SIZE_DEF = 16;
  localparam int unsigned SUB_BITS      = 4;
  localparam int unsigned EW            = 48;
  localparam int unsigned SW            = 24;
  localparam int unsigned CW            = 13;
  localparam int unsigned XW            = 14;

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [SW-1:0] step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SU_BOX,
    ST_SU_EDGE,
    ST_SU_DONE,
    ST_TQ_WT,
    ST_TQ_CLASS,
    ST_TQ_ROWS
  } state_e;

  localparam logic       OP_SETUP = 1'b0;
  localparam logic       OP_TILE  = 1'b1;

  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_CULLED = 2'd1;
  localparam logic [1:0] STAT_ZERO   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  localparam logic [1:0] CLS_REJECT  = 2'd0;
  localparam logic [1:0] CLS_FULL    = 2'd1;
  localparam logic [1:0] CLS_PARTIAL = 2'd2;

  localparam logic [1:0] CULL_FRONT = 2'd1;
  localparam logic [1:0] CULL_BACK  = 2'd2;

  localparam logic [2:0] REG_CULL_MODE    = 3'd0;
  localparam logic [2:0] REG_FRONT_IS_CCW = 3'd1;
  localparam logic [2:0] REG_CLIP_MIN_X   = 3'd2;
  localparam logic [2:0] REG_CLIP_MIN_Y   = 3'd3;
  localparam logic [2:0] REG_CLIP_MAX_X   = 3'd4;
  localparam logic [2:0] REG_CLIP_MAX_Y   = 3'd5;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic [15:0] coverage_mask;
    logic [11:0] tile_left_x;
    logic [11:0] pixel_row;
    logic [1:0]  tile_class;
    logic [8:0]  tiles_down;
    logic [8:0]  tiles_across;
    logic [1:0]  setup_status;
  } result_t;

endpackage

FILE: sv/ttcr_cell.sv
module ttcr_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  ttcr_pkg::cell_ctrl_t ctrl_i,
  input  ttcr_pkg::edge_t      base_i  [3],
  input  ttcr_pkg::step_t      stepx_i [3],
  input  ttcr_pkg::step_t      stepy_i [3],
  output logic                 covered_o
);

  localparam logic signed [5:0] IDX_S = 6'(IDX);

  ttcr_pkg::edge_t w_q [3];

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 3; e++) begin
      if (ctrl_i.load) begin
        w_q[e] <= base_i[e] + ttcr_pkg::EW'(stepx_i[e] * IDX_S);
      end else if (ctrl_i.step) begin
        w_q[e] <= w_q[e] + ttcr_pkg::EW'(stepy_i[e]);
      end
    end
  end

  assign covered_o = !w_q[0][ttcr_pkg::EW-1] && !w_q[1][ttcr_pkg::EW-1]
                  && !w_q[2][ttcr_pkg::EW-1];

endmodule

FILE: sv/triangle_tile_coverage_rasterizer_core.sv
// Edge-function triangle rasterizer with tiled coverage. A setup request
// (tuser 0) passes through a sequence of area, box and edge stages and
// returns one result with status and tile counts. A tile request (tuser 1)
// passes through corner classification and then returns either one reject
// result or one coverage mask per pixel row inside the box, one row per cycle
// while the output is not stalled; the row of TILE_SIZE pixel cells sets that
// rate. One request is buffered at the input while the engine works and one
// result is held at the output.
`include "triangle_tile_coverage_rasterizer_core_macros.svh"

module triangle_tile_coverage_rasterizer_core #(
  parameter int unsigned TILE_SIZE = ttcr_pkg::TILE_SIZE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, tile_col, tile_row
  input  logic [111:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // setup_status, tiles_across, tiles_down, tile_class, pixel_row,
  // tile_left_x, coverage_mask, 2 zero bits
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_wr_en_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [12:0]  cfg_wdata_i
);

  localparam int unsigned TB   = $clog2(TILE_SIZE + 1);
  localparam int unsigned CTW  = $clog2(256 * TILE_SIZE);
  localparam int unsigned RSH  = 20;
  localparam logic [34:0] RECIP = 35'((2 ** RSH + TILE_SIZE - 1) / TILE_SIZE);
  localparam logic [TB-1:0] TS = TB'(TILE_SIZE);
  localparam logic signed [5:0] TM1 = 6'(TILE_SIZE - 1);
  localparam int unsigned EW = ttcr_pkg::EW;
  localparam int unsigned XW = ttcr_pkg::XW;

  function automatic logic [11:0] div_tile(input logic [13:0] v);
    logic [34:0] p;
    p = 35'(v) * RECIP;
    return p[RSH +: 12];
  endfunction

  // configuration
  logic [1:0]  cull_q;
  logic        fccw_q;
  logic [12:0] clip_min_x_q, clip_min_y_q, clip_max_x_q, clip_max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_q       <= ttcr_pkg::CULL_BACK;
      fccw_q       <= 1'b0;
      clip_min_x_q <= '0;
      clip_min_y_q <= '0;
      clip_max_x_q <= 13'd4096;
      clip_max_y_q <= 13'd4096;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_addr_i)
        ttcr_pkg::REG_CULL_MODE:    cull_q       <= cfg_wdata_i[1:0];
        ttcr_pkg::REG_FRONT_IS_CCW: fccw_q       <= cfg_wdata_i[0];
        ttcr_pkg::REG_CLIP_MIN_X:   clip_min_x_q <= cfg_wdata_i;
        ttcr_pkg::REG_CLIP_MIN_Y:   clip_min_y_q <= cfg_wdata_i;
        ttcr_pkg::REG_CLIP_MAX_X:   clip_max_x_q <= cfg_wdata_i;
        ttcr_pkg::REG_CLIP_MAX_Y:   clip_max_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input buffer
  logic         hold_valid_q;
  logic         hold_op_q;
  logic [111:0] hold_data_q;
  logic         take;
  ttcr_pkg::state_e state_q, state_d;

  assign s_axis_tready = !hold_valid_q;
  assign take = (state_q == ttcr_pkg::ST_IDLE) && hold_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      hold_valid_q <= 1'b1;
    end else if (take) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_op_q   <= s_axis_tuser;
      hold_data_q <= s_axis_tdata;
    end
  end

  logic signed [15:0] hx [3];
  logic signed [15:0] hy [3];
  logic [7:0] h_col, h_row;

  for (genvar e = 0; e < 3; e++) begin : g_unpack
    assign hx[e] = hold_data_q[32*e +: 16];
    assign hy[e] = hold_data_q[32*e+16 +: 16];
  end
  assign h_col = hold_data_q[103:96];
  assign h_row = hold_data_q[111:104];

  // triangle state
  ttcr_pkg::edge_t origin_q [3];
  ttcr_pkg::step_t stepx_q  [3];
  ttcr_pkg::step_t stepy_q  [3];
  logic [12:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
  logic [12:0] ao_x_q, ao_y_q;
  logic [8:0]  cnt_x_q, cnt_y_q;
  logic        tri_valid_q;

  // setup working registers
  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic signed [33:0] p1_q, p2_q;
  logic signed [35:0] q1_q [3];
  logic signed [35:0] q2_q [3];
  logic [2:0] tl_q;
  ttcr_pkg::step_t nsx_q [3];
  ttcr_pkg::step_t nsy_q [3];
  logic [8:0] ncx_q, ncy_q;

  // query working registers
  logic [XW-1:0] tx_q, ty_q;
  logic          inr_q;
  ttcr_pkg::edge_t pxp_q [3];
  ttcr_pkg::edge_t pyp_q [3];
  ttcr_pkg::edge_t cxp_q [3];
  ttcr_pkg::edge_t cyp_q [3];
  ttcr_pkg::edge_t offp_q [3];
  ttcr_pkg::edge_t wt_q  [3];
  ttcr_pkg::edge_t base  [3];
  logic [TB-1:0] lox_off_q, hix_off_q, loy_off_q, hiy_off_q, row_off_q;
  logic [1:0]    cls_q;

  // setup combinational pieces
  logic signed [16:0] d10x, d10y, d20x, d20y;
  logic signed [34:0] area;
  logic               front, culled, swap;
  logic signed [15:0] mnx0, mny0, mxx0, mxy0;
  logic signed [14:0] mnx, mny, mxx, mxy;
  logic               empty_box;
  logic [12:0]        ao_x_n, ao_y_n;

  assign d10x = 17'(vx_q[1]) - 17'(vx_q[0]);
  assign d10y = 17'(vy_q[1]) - 17'(vy_q[0]);
  assign d20x = 17'(hx[2]) - 17'(hx[0]);
  assign d20y = 17'(hy[2]) - 17'(hy[0]);

  assign area   = 35'(p1_q) - 35'(p2_q);
  assign front  = fccw_q ? (area > 0) : (area < 0);
  assign culled = (cull_q == ttcr_pkg::CULL_BACK && !front)
               || (cull_q == ttcr_pkg::CULL_FRONT && front);
  assign swap   = area < 0;

  always_comb begin
    mnx0 = vx_q[0];
    mny0 = vy_q[0];
    mxx0 = vx_q[0];
    mxy0 = vy_q[0];
    for (int e = 1; e < 3; e++) begin
      if (vx_q[e] < mnx0) mnx0 = vx_q[e];
      if (vy_q[e] < mny0) mny0 = vy_q[e];
      if (vx_q[e] > mxx0) mxx0 = vx_q[e];
      if (vy_q[e] > mxy0) mxy0 = vy_q[e];
    end
    mnx = 15'(mnx0 >>> ttcr_pkg::SUB_BITS);
    mny = 15'(mny0 >>> ttcr_pkg::SUB_BITS);
    mxx = 15'((17'(mxx0) + 17'sd15) >>> ttcr_pkg::SUB_BITS);
    mxy = 15'((17'(mxy0) + 17'sd15) >>> ttcr_pkg::SUB_BITS);
    if (mnx < $signed({2'b0, clip_min_x_q})) mnx = $signed({2'b0, clip_min_x_q});
    if (mny < $signed({2'b0, clip_min_y_q})) mny = $signed({2'b0, clip_min_y_q});
    if (mxx > $signed({2'b0, clip_max_x_q})) mxx = $signed({2'b0, clip_max_x_q});
    if (mxy > $signed({2'b0, clip_max_y_q})) mxy = $signed({2'b0, clip_max_y_q});
    empty_box = (mnx >= mxx) || (mny >= mxy);
    ao_x_n = 13'(div_tile(14'(mnx[12:0])) * 12'(TILE_SIZE));
    ao_y_n = 13'(div_tile(14'(mny[12:0])) * 12'(TILE_SIZE));
  end

  logic [11:0] qx, qy;
  assign qx = div_tile(14'(box_max_x_q) - 14'(ao_x_q) + 14'(TILE_SIZE - 1));
  assign qy = div_tile(14'(box_max_y_q) - 14'(ao_y_q) + 14'(TILE_SIZE - 1));

  logic signed [17:0] sx, sy;
  assign sx = $signed({1'b0, ao_x_q, 4'b1000});
  assign sy = $signed({1'b0, ao_y_q, 4'b1000});

  logic signed [35:0] q1_n [3];
  logic signed [35:0] q2_n [3];
  logic [2:0]         tl_n;
  ttcr_pkg::step_t    nsx_n [3];
  ttcr_pkg::step_t    nsy_n [3];

  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int A = (e + 1) % 3;
    localparam int B = (e + 2) % 3;
    logic signed [16:0] ex, ey;
    logic signed [18:0] ox, oy;
    assign ex = 17'(vx_q[B]) - 17'(vx_q[A]);
    assign ey = 17'(vy_q[B]) - 17'(vy_q[A]);
    assign ox = 19'(sx) - 19'(vx_q[A]);
    assign oy = 19'(sy) - 19'(vy_q[A]);
    assign q1_n[e] = 36'(ex * oy);
    assign q2_n[e] = 36'(ey * ox);
    assign tl_n[e] = (ey == 0 && ex > 0) || (ey < 0);
    assign nsx_n[e] = 24'(-(24'(ey) <<< ttcr_pkg::SUB_BITS));
    assign nsy_n[e] = 24'(24'(ex) <<< ttcr_pkg::SUB_BITS);
  end

  // query combinational pieces
  logic [CTW-1:0] colt, rowt;
  logic [XW-1:0]  tx_n, ty_n, lox, hix, loy, hiy, tx_end, ty_end;
  logic           inr_n;

  assign colt  = CTW'(h_col) * CTW'(TILE_SIZE);
  assign rowt  = CTW'(h_row) * CTW'(TILE_SIZE);
  assign tx_n  = XW'(ao_x_q) + XW'(colt);
  assign ty_n  = XW'(ao_y_q) + XW'(rowt);
  assign inr_n = (9'(h_col) < cnt_x_q) && (9'(h_row) < cnt_y_q);
  assign tx_end = tx_q + XW'(TILE_SIZE);
  assign ty_end = ty_q + XW'(TILE_SIZE);
  assign lox = (tx_q > XW'(box_min_x_q)) ? tx_q : XW'(box_min_x_q);
  assign loy = (ty_q > XW'(box_min_y_q)) ? ty_q : XW'(box_min_y_q);
  assign hix = (tx_end < XW'(box_max_x_q)) ? tx_end : XW'(box_max_x_q);
  assign hiy = (ty_end < XW'(box_max_y_q)) ? ty_end : XW'(box_max_y_q);

  logic [2:0] rej_e, part_e;
  logic       reject, full;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      automatic ttcr_pkg::edge_t c1 = wt_q[e] + cxp_q[e];
      automatic ttcr_pkg::edge_t c2 = wt_q[e] + cyp_q[e];
      automatic ttcr_pkg::edge_t c3 = c1 + cyp_q[e];
      rej_e[e]  = wt_q[e][EW-1] && c1[EW-1] && c2[EW-1] && c3[EW-1];
      part_e[e] = wt_q[e][EW-1] || c1[EW-1] || c2[EW-1] || c3[EW-1];
      base[e]   = wt_q[e] + offp_q[e];
    end
    reject = |rej_e;
    full   = !(|part_e);
  end

  // output register
  logic               out_valid_q, out_last_q;
  ttcr_pkg::result_t  out_q, res;
  logic               out_free, out_load, res_last;

  assign out_free = !out_valid_q || m_axis_tready;

  // pixel cells
  ttcr_pkg::cell_ctrl_t   cell_ctrl;
  logic [TILE_SIZE-1:0]   cov;
  logic [15:0]            row_mask;
  logic                   row_last;

  for (genvar i = 0; i < TILE_SIZE; i++) begin : g_cell
    ttcr_cell #(.IDX(i)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .base_i    (base),
      .stepx_i   (stepx_q),
      .stepy_i   (stepy_q),
      .covered_o (cov[i])
    );
  end

  always_comb begin
    row_mask = '0;
    for (int i = 0; i < TILE_SIZE; i++) begin
      row_mask[i] = (TB'(i) >= lox_off_q) && (TB'(i) < hix_off_q)
                 && ((cls_q == ttcr_pkg::CLS_FULL) || cov[i]);
    end
  end
  assign row_last = (row_off_q + TB'(1)) >= hiy_off_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttcr_pkg::ST_IDLE: begin
        if (take) begin
          state_d = (hold_op_q == ttcr_pkg::OP_SETUP) ? ttcr_pkg::ST_SU_BOX
                                                     : ttcr_pkg::ST_TQ_WT;
        end
      end
      ttcr_pkg::ST_SU_BOX: begin
        if (!(culled || area == 0 || empty_box)) begin
          state_d = ttcr_pkg::ST_SU_EDGE;
        end else if (out_free) begin
          state_d = ttcr_pkg::ST_IDLE;
        end
      end
      ttcr_pkg::ST_SU_EDGE: state_d = ttcr_pkg::ST_SU_DONE;
      ttcr_pkg::ST_SU_DONE: begin
        if (out_free) state_d = ttcr_pkg::ST_IDLE;
      end
      ttcr_pkg::ST_TQ_WT: begin
        if (tri_valid_q && inr_q) begin
          state_d = ttcr_pkg::ST_TQ_CLASS;
        end else if (out_free) begin
          state_d = ttcr_pkg::ST_IDLE;
        end
      end
      ttcr_pkg::ST_TQ_CLASS: begin
        if (!reject) begin
          state_d = ttcr_pkg::ST_TQ_ROWS;
        end else if (out_free) begin
          state_d = ttcr_pkg::ST_IDLE;
        end
      end
      ttcr_pkg::ST_TQ_ROWS: begin
        if (out_free && row_last) state_d = ttcr_pkg::ST_IDLE;
      end
      default: state_d = ttcr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load       = 1'b0;
    res            = '0;
    res_last       = 1'b1;
    cell_ctrl.load = 1'b0;
    cell_ctrl.step = 1'b0;
    unique case (state_q)
      ttcr_pkg::ST_SU_BOX: begin
        out_load = out_free && (culled || area == 0 || empty_box);
        priority if (culled) res.setup_status = ttcr_pkg::STAT_CULLED;
        else if (area == 0)  res.setup_status = ttcr_pkg::STAT_ZERO;
        else                 res.setup_status = ttcr_pkg::STAT_EMPTY;
      end
      ttcr_pkg::ST_SU_DONE: begin
        out_load          = out_free;
        res.setup_status  = ttcr_pkg::STAT_ACCEPT;
        res.tiles_across  = ncx_q;
        res.tiles_down    = ncy_q;
      end
      ttcr_pkg::ST_TQ_WT: begin
        out_load = out_free && !(tri_valid_q && inr_q);
        if (tri_valid_q) begin
          res.pixel_row   = ty_q[11:0];
          res.tile_left_x = tx_q[11:0];
        end
      end
      ttcr_pkg::ST_TQ_CLASS: begin
        out_load        = out_free && reject;
        res.pixel_row   = ty_q[11:0];
        res.tile_left_x = tx_q[11:0];
        cell_ctrl.load  = !reject;
      end
      ttcr_pkg::ST_TQ_ROWS: begin
        out_load          = out_free;
        res.tile_class    = cls_q;
        res.pixel_row     = 12'(ty_q + XW'(row_off_q));
        res.tile_left_x   = tx_q[11:0];
        res.coverage_mask = row_mask;
        res_last          = row_last;
        cell_ctrl.step    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttcr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      tri_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (take && hold_op_q == ttcr_pkg::OP_SETUP) begin
        tri_valid_q <= 1'b0;
      end else if (state_q == ttcr_pkg::ST_SU_DONE && out_free) begin
        tri_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= res;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};
  assign m_axis_tlast  = out_last_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int e = 0; e < 3; e++) begin
        vx_q[e]  <= hx[e];
        vy_q[e]  <= hy[e];
        pxp_q[e] <= EW'(stepx_q[e] * $signed({1'b0, colt}));
        pyp_q[e] <= EW'(stepy_q[e] * $signed({1'b0, rowt}));
        cxp_q[e] <= EW'(stepx_q[e] * TM1);
        cyp_q[e] <= EW'(stepy_q[e] * TM1);
      end
      p1_q  <= 34'((17'(hx[1]) - 17'(hx[0])) * d20y);
      p2_q  <= 34'((17'(hy[1]) - 17'(hy[0])) * d20x);
      tx_q  <= tx_n;
      ty_q  <= ty_n;
      inr_q <= inr_n;
    end
    if (state_q == ttcr_pkg::ST_SU_BOX && !(culled || area == 0 || empty_box)) begin
      if (swap) begin
        vx_q[1] <= vx_q[2];
        vx_q[2] <= vx_q[1];
        vy_q[1] <= vy_q[2];
        vy_q[2] <= vy_q[1];
      end
      box_min_x_q <= mnx[12:0];
      box_min_y_q <= mny[12:0];
      box_max_x_q <= mxx[12:0];
      box_max_y_q <= mxy[12:0];
      ao_x_q      <= ao_x_n;
      ao_y_q      <= ao_y_n;
    end
    if (state_q == ttcr_pkg::ST_SU_EDGE) begin
      for (int e = 0; e < 3; e++) begin
        q1_q[e]  <= q1_n[e];
        q2_q[e]  <= q2_n[e];
        nsx_q[e] <= nsx_n[e];
        nsy_q[e] <= nsy_n[e];
      end
      tl_q  <= tl_n;
      ncx_q <= (qx > 12'd511) ? 9'd511 : qx[8:0];
      ncy_q <= (qy > 12'd511) ? 9'd511 : qy[8:0];
    end
    if (state_q == ttcr_pkg::ST_SU_DONE && out_free) begin
      for (int e = 0; e < 3; e++) begin
        origin_q[e] <= EW'(37'(q1_q[e]) - 37'(q2_q[e])) - (tl_q[e] ? EW'(0) : EW'(1));
        stepx_q[e]  <= nsx_q[e];
        stepy_q[e]  <= nsy_q[e];
      end
      cnt_x_q <= ncx_q;
      cnt_y_q <= ncy_q;
    end
    if (state_q == ttcr_pkg::ST_TQ_WT) begin
      for (int e = 0; e < 3; e++) begin
        wt_q[e]   <= origin_q[e] + pxp_q[e] + pyp_q[e];
        offp_q[e] <= EW'(stepy_q[e] * $signed({1'b0, TB'(loy - ty_q)}));
      end
      lox_off_q <= TB'(lox - tx_q);
      hix_off_q <= TB'(hix - tx_q);
      loy_off_q <= TB'(loy - ty_q);
      hiy_off_q <= TB'(hiy - ty_q);
    end
    if (state_q == ttcr_pkg::ST_TQ_CLASS) begin
      cls_q     <= full ? ttcr_pkg::CLS_FULL : ttcr_pkg::CLS_PARTIAL;
      row_off_q <= loy_off_q;
    end else if (cell_ctrl.step) begin
      row_off_q <= row_off_q + TB'(1);
    end
  end

  `TTCR_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |-> (state_q == ttcr_pkg::ST_IDLE && !out_valid_q), "engine not idle in reset")
  `TTCR_ASSERT(a_last_idle, clk_i, rst_ni, (out_load && res_last) |=> state_q == ttcr_pkg::ST_IDLE, "engine busy after final result")
  `TTCR_ASSERT(a_row_bound, clk_i, rst_ni, state_q == ttcr_pkg::ST_TQ_ROWS |-> row_off_q < hiy_off_q, "row walk past box")
  `TTCR_ASSERT(a_ts_used, clk_i, rst_ni, cell_ctrl.load |-> (lox_off_q < hix_off_q && hix_off_q <= TS), "column window out of tile")

endmodule

FILE: bench/tb_triangle_tile_coverage_rasterizer_core.sv
module tb_triangle_tile_coverage_rasterizer_core;
  import ttcr_pkg::*;

  typedef struct {
    result_t r;
    logic    last;
  } raster_out_s;

  // one row of the directed plan: a register write or a request
  // typed: -1 predicted, 0..3 rejected setup with that status, 4 empty query
  typedef struct {
    bit         is_cfg;
    logic [2:0] addr;
    int         val;
    logic       op;
    int         x0, y0, x1, y1, x2, y2;
    int         col, row;
    int         typed;
  } plan_s;

  localparam int TYPED_NOTRI = 4;
  localparam int NPLAN = 26;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_wr_en_i;
  logic [2:0]   cfg_addr_i;
  logic [12:0]  cfg_wdata_i;

  triangle_tile_coverage_rasterizer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // rasterizer shadow state
  longint cull_mode_q, front_ccw_q, clip_x0_q, clip_y0_q, clip_x1_q, clip_y1_q;
  longint edge_org_q [3];
  longint edge_dx_q [3];
  longint edge_dy_q [3];
  longint bbox_x0_q, bbox_y0_q, bbox_x1_q, bbox_y1_q, org_x_q, org_y_q;
  bit     tri_valid_q;

  raster_out_s mask_rows_q[$];
  int errors, n_setup, n_query, n_rows;
  bit gaps_on, stall_on;

  plan_s plan [NPLAN] = '{
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 0, 0, TYPED_NOTRI},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 0, 0, 256, 0, 0, 256, 0, 0, int'(STAT_CULLED)},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 0, 0, 256, 256, 512, 512, 0, 0, int'(STAT_CULLED)},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 88, 40, 40, 600, 700, 300, 0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 1, 1, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 2, 2, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 1, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 3, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 255, 255, -1},
    '{0, REG_CULL_MODE, 0, OP_SETUP, -32768, -32768, -32768, 32767, 32767, -32768,
      0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 127, 127, -1},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CULL_MODE, 0, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 0, 0, 256, 256, 512, 512, 0, 0, int'(STAT_ZERO)},
    '{1, REG_CLIP_MIN_X, 4096, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CLIP_MAX_X, 0, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CLIP_MIN_Y, 4096, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CLIP_MAX_Y, 0, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 88, 40, 40, 600, 700, 300, 0, 0, int'(STAT_EMPTY)},
    '{0, REG_CULL_MODE, 0, OP_TILE, 0, 0, 0, 0, 0, 0, 0, 0, TYPED_NOTRI},
    '{1, REG_CLIP_MIN_X, 0, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CLIP_MAX_X, 4096, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_FRONT_IS_CCW, 1, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{1, REG_CULL_MODE, 3, OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, -1},
    '{0, REG_CULL_MODE, 0, OP_SETUP, 8, 8, 900, 40, 300, 500, 0, 0, -1}
  };

  function automatic longint floor_px(longint v);
    return v >= 0 ? v / 16 : -((-v + 15) / 16);
  endfunction

  function automatic longint tiles_spanned(longint lo, longint hi);
    longint n;
    n = (hi - lo + TILE_SIZE_DEF - 1) / TILE_SIZE_DEF;
    if (n < 0) n = 0;
    return n > 511 ? 511 : n;
  endfunction

  function automatic void push_row(longint st, longint ta, longint td, longint cls,
                                   longint row, longint left, longint mask, bit last);
    raster_out_s o;
    o.r.setup_status  = st[1:0];
    o.r.tiles_across  = ta[8:0];
    o.r.tiles_down    = td[8:0];
    o.r.tile_class    = cls[1:0];
    o.r.pixel_row     = row[11:0];
    o.r.tile_left_x   = left[11:0];
    o.r.coverage_mask = mask[15:0];
    o.last            = last;
    mask_rows_q.push_back(o);
  endfunction

  function automatic void setup_triangle(logic [111:0] d);
    longint x [3];
    longint y [3];
    longint t, area, mnx, mny, mxx, mxy, sx, sy, ex, ey;
    bit front;
    int a, b;
    for (int e = 0; e < 3; e++) begin
      x[e] = longint'($signed(d[32*e +: 16]));
      y[e] = longint'($signed(d[32*e+16 +: 16]));
    end
    tri_valid_q = 0;
    area = (x[1] - x[0]) * (y[2] - y[0]) - (y[1] - y[0]) * (x[2] - x[0]);
    front = front_ccw_q != 0 ? area > 0 : area < 0;
    if ((cull_mode_q == CULL_BACK && !front) || (cull_mode_q == CULL_FRONT && front)) begin
      push_row(STAT_CULLED, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (area == 0) begin
      push_row(STAT_ZERO, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (area < 0) begin
      t = x[1]; x[1] = x[2]; x[2] = t;
      t = y[1]; y[1] = y[2]; y[2] = t;
    end
    mnx = floor_px(x[0] < x[1] ? (x[0] < x[2] ? x[0] : x[2]) : (x[1] < x[2] ? x[1] : x[2]));
    mny = floor_px(y[0] < y[1] ? (y[0] < y[2] ? y[0] : y[2]) : (y[1] < y[2] ? y[1] : y[2]));
    mxx = floor_px((x[0] > x[1] ? (x[0] > x[2] ? x[0] : x[2])
                                : (x[1] > x[2] ? x[1] : x[2])) + 15);
    mxy = floor_px((y[0] > y[1] ? (y[0] > y[2] ? y[0] : y[2])
                                : (y[1] > y[2] ? y[1] : y[2])) + 15);
    if (mnx < clip_x0_q) mnx = clip_x0_q;
    if (mny < clip_y0_q) mny = clip_y0_q;
    if (mxx > clip_x1_q) mxx = clip_x1_q;
    if (mxy > clip_y1_q) mxy = clip_y1_q;
    if (mnx >= mxx || mny >= mxy) begin
      push_row(STAT_EMPTY, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    bbox_x0_q = mnx; bbox_y0_q = mny; bbox_x1_q = mxx; bbox_y1_q = mxy;
    org_x_q = mnx - mnx % TILE_SIZE_DEF;
    org_y_q = mny - mny % TILE_SIZE_DEF;
    sx = org_x_q * 16 + 8;
    sy = org_y_q * 16 + 8;
    for (int e = 0; e < 3; e++) begin
      a = (e + 1) % 3;
      b = (e + 2) % 3;
      ex = x[b] - x[a];
      ey = y[b] - y[a];
      edge_org_q[e] = ex * (sy - y[a]) - ey * (sx - x[a])
                      + (((ey == 0 && ex > 0) || ey < 0) ? 0 : -1);
      edge_dx_q[e] = -ey * 16;
      edge_dy_q[e] = ex * 16;
    end
    tri_valid_q = 1;
    push_row(STAT_ACCEPT, tiles_spanned(org_x_q, bbox_x1_q),
             tiles_spanned(org_y_q, bbox_y1_q), 0, 0, 0, 0, 1);
  endfunction

  function automatic void cover_tile(logic [111:0] d);
    longint col, row, tx, ty, lox, hix, loy, hiy, w, c0, c1, c2, c3, mask;
    longint wt [3];
    bit reject, full, in_all;
    int n;
    col = d[103:96];
    row = d[111:104];
    reject = 0;
    full = 1;
    n = 0;
    if (!tri_valid_q) begin
      push_row(0, 0, 0, CLS_REJECT, 0, 0, 0, 1);
      return;
    end
    tx = org_x_q + col * TILE_SIZE_DEF;
    ty = org_y_q + row * TILE_SIZE_DEF;
    if (col >= tiles_spanned(org_x_q, bbox_x1_q) || row >= tiles_spanned(org_y_q, bbox_y1_q))
    begin
      push_row(0, 0, 0, CLS_REJECT, ty, tx, 0, 1);
      return;
    end
    for (int e = 0; e < 3; e++) begin
      wt[e] = edge_org_q[e] + col * TILE_SIZE_DEF * edge_dx_q[e]
              + row * TILE_SIZE_DEF * edge_dy_q[e];
      c0 = wt[e];
      c1 = c0 + edge_dx_q[e] * (TILE_SIZE_DEF - 1);
      c2 = c0 + edge_dy_q[e] * (TILE_SIZE_DEF - 1);
      c3 = c1 + edge_dy_q[e] * (TILE_SIZE_DEF - 1);
      if (c0 < 0 && c1 < 0 && c2 < 0 && c3 < 0) reject = 1;
      if (c0 < 0 || c1 < 0 || c2 < 0 || c3 < 0) full = 0;
    end
    if (reject) begin
      push_row(0, 0, 0, CLS_REJECT, ty, tx, 0, 1);
      return;
    end
    lox = tx > bbox_x0_q ? tx : bbox_x0_q;
    hix = tx + TILE_SIZE_DEF < bbox_x1_q ? tx + TILE_SIZE_DEF : bbox_x1_q;
    loy = ty > bbox_y0_q ? ty : bbox_y0_q;
    hiy = ty + TILE_SIZE_DEF < bbox_y1_q ? ty + TILE_SIZE_DEF : bbox_y1_q;
    for (longint py = loy; py < hiy && n < TILE_SIZE_DEF; py++) begin
      mask = 0;
      for (longint px = lox; px < hix; px++) begin
        in_all = 1;
        for (int e = 0; e < 3; e++) begin
          w = wt[e] + edge_dx_q[e] * (px - tx) + edge_dy_q[e] * (py - ty);
          if (w < 0) in_all = 0;
        end
        if (full || in_all) mask = mask | (longint'(1) << ((px - tx) & 15));
      end
      push_row(0, 0, 0, full ? CLS_FULL : CLS_PARTIAL, py, tx, mask, py + 1 >= hiy);
      n++;
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] addr, int val);
    cfg_wr_en_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val[12:0];
    @(posedge clk_i);
    case (addr)
      REG_CULL_MODE:    cull_mode_q = val & 3;
      REG_FRONT_IS_CCW: front_ccw_q = val & 1;
      REG_CLIP_MIN_X:   clip_x0_q = val & 'h1FFF;
      REG_CLIP_MIN_Y:   clip_y0_q = val & 'h1FFF;
      REG_CLIP_MAX_X:   clip_x1_q = val & 'h1FFF;
      REG_CLIP_MAX_Y:   clip_y1_q = val & 'h1FFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mask_rows_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // typed < 0: predicted; otherwise the typed-in single result replaces it
  task automatic send_request(logic op, logic [111:0] d, int typed);
    int depth;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    depth = mask_rows_q.size();
    if (op == OP_SETUP) begin
      setup_triangle(d);
      n_setup++;
    end else begin
      cover_tile(d);
      n_query++;
    end
    if (typed >= 0) begin
      while (mask_rows_q.size() > depth) void'(mask_rows_q.pop_back());
      push_row(typed == TYPED_NOTRI ? 0 : typed, 0, 0, CLS_REJECT, 0, 0, 0, 1);
    end
  endtask

  function automatic logic [111:0] tri_req(longint x0, longint y0, longint x1, longint y1,
                                           longint x2, longint y2);
    return {16'h0, y2[15:0], x2[15:0], y1[15:0], x1[15:0], y0[15:0], x0[15:0]};
  endfunction

  function automatic logic [111:0] tile_req(int col, int row);
    logic [111:0] d;
    d = {$urandom(), $urandom(), $urandom(), $urandom()};
    d[103:96]  = col[7:0];
    d[111:104] = row[7:0];
    return d;
  endfunction

  task automatic random_setup();
    logic [111:0] d;
    longint bx, by;
    if ($urandom_range(0, 7) == 0) begin
      d = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      bx = $urandom_range(0, 320) * 16;
      by = $urandom_range(0, 240) * 16;
      d = tri_req(bx + $urandom_range(0, 640), by + $urandom_range(0, 640),
                  bx + $urandom_range(0, 640), by + $urandom_range(0, 640),
                  bx + $urandom_range(0, 640), by + $urandom_range(0, 640));
      if ($urandom_range(0, 15) == 0) d[79:64] = d[15:0] + d[47:32] - d[15:0];
    end
    send_request(OP_SETUP, d, -1);
  endtask

  task automatic random_query();
    longint across, down;
    across = tri_valid_q ? tiles_spanned(org_x_q, bbox_x1_q) : 1;
    down   = tri_valid_q ? tiles_spanned(org_y_q, bbox_y1_q) : 1;
    if (across > 256) across = 256;
    if (down > 256) down = 256;
    if ($urandom_range(0, 5) == 0)
      send_request(OP_TILE, tile_req($urandom_range(0, 255), $urandom_range(0, 255)), -1);
    else
      send_request(OP_TILE, tile_req($urandom_range(0, across - 1),
                                     $urandom_range(0, down - 1)), -1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    raster_out_s want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[61:0]);
      n_rows++;
      if (mask_rows_q.size() == 0) begin
        $display("unexpected result 0x%h", m_axis_tdata);
        errors++;
      end else begin
        want = mask_rows_q.pop_front();
        if (got.setup_status != want.r.setup_status)
          report("setup_status", got.setup_status, want.r.setup_status);
        if (got.tiles_across != want.r.tiles_across)
          report("tiles_across", got.tiles_across, want.r.tiles_across);
        if (got.tiles_down != want.r.tiles_down)
          report("tiles_down", got.tiles_down, want.r.tiles_down);
        if (got.tile_class != want.r.tile_class)
          report("tile_class", got.tile_class, want.r.tile_class);
        if (got.pixel_row != want.r.pixel_row)
          report("pixel_row", got.pixel_row, want.r.pixel_row);
        if (got.tile_left_x != want.r.tile_left_x)
          report("tile_left_x", got.tile_left_x, want.r.tile_left_x);
        if (got.coverage_mask != want.r.coverage_mask)
          report("coverage_mask", got.coverage_mask, want.r.coverage_mask);
        if (m_axis_tdata[63:62] != 2'b00) report("pad bits", m_axis_tdata[63:62], 0);
        if (m_axis_tlast !== want.last) report("tlast", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("tb_triangle_tile_coverage_rasterizer_core NOT OK");
    $finish;
  end

  initial begin
    int phase_cfg [4][6] = '{
      '{0, 0, 0, 0, 4096, 4096},
      '{1, 1, 0, 0, 4096, 4096},
      '{2, 1, 24, 8, 300, 200},
      '{3, 0, 0, 0, 4096, 4096}
    };
    errors = 0;
    n_setup = 0;
    n_query = 0;
    n_rows = 0;
    gaps_on = 1;
    stall_on = 1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    cull_mode_q = CULL_BACK;
    front_ccw_q = 0;
    clip_x0_q = 0;
    clip_y0_q = 0;
    clip_x1_q = 4096;
    clip_y1_q = 4096;
    for (int e = 0; e < 3; e++) begin
      edge_org_q[e] = 0;
      edge_dx_q[e] = 0;
      edge_dy_q[e] = 0;
    end
    bbox_x0_q = 0; bbox_y0_q = 0; bbox_x1_q = 0; bbox_y1_q = 0;
    org_x_q = 0; org_y_q = 0;
    tri_valid_q = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NPLAN; i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain();
        write_reg(plan[i].addr, plan[i].val);
        if (i + 1 >= NPLAN || !plan[i+1].is_cfg) cfg_wr_en_i <= 1'b0;
      end else if (plan[i].op == OP_SETUP) begin
        send_request(OP_SETUP, tri_req(plan[i].x0, plan[i].y0, plan[i].x1, plan[i].y1,
                                       plan[i].x2, plan[i].y2), plan[i].typed);
      end else begin
        send_request(OP_TILE, tile_req(plan[i].col, plan[i].row), plan[i].typed);
      end
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      for (int r = 0; r < 6; r++) write_reg(r[2:0], phase_cfg[p][r]);
      cfg_wr_en_i <= 1'b0;
      for (int k = 0; k < 36; k++) begin
        gaps_on = p < 3 && $urandom_range(0, 4) != 0;
        stall_on = p < 3 && $urandom_range(0, 4) != 0;
        if (k % 4 == 0 || !tri_valid_q && $urandom_range(0, 1) == 0) random_setup();
        else random_query();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (mask_rows_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d triangle setups and %0d tile queries, %0d results checked",
             n_setup, n_query, n_rows);
    $display("register settings: reset, cull none/front/back/unused, inverted and narrow clip");
    if (errors == 0) begin
      $display("tb_triangle_tile_coverage_rasterizer_core OK");
    end else begin
      $display("tb_triangle_tile_coverage_rasterizer_core NOT OK");
    end
    $finish;
  end

endmodule

FILE: triangle_tile_coverage_rasterizer_core.f
+incdir+sv
sv/ttcr_pkg.sv
sv/ttcr_cell.sv
sv/triangle_tile_coverage_rasterizer_core.sv
bench/tb_triangle_tile_coverage_rasterizer_core.sv
